>>> sv/prb_pkg.sv
// ----------------------------------------------------------------------------
// prb_pkg: shared definitions of the palette rectangle blitter.
// Screen geometry, palette size, register indexes and the structures that
// travel between the configuration block, the walker and the top level.
// ----------------------------------------------------------------------------
package prb_pkg;

	// Screen and palette geometry.
	localparam int SCREEN_WIDTH  = 640;
	localparam int SCREEN_HEIGHT = 360;
	localparam int PAL_DEPTH     = 256;
	localparam int PAL_AW        = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;

	// Width for coordinate compares, wide enough for the largest screen.
	localparam int COORD_W = 13;

	// Configuration port widths.
	localparam int REG_IDX_W  = 3;
	localparam int REG_DATA_W = 10;

	// Input commands.
	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_STEP = 1'b1
	} cmd_t;

	// Register indexes of the configuration port.
	typedef enum logic [REG_IDX_W-1:0] {
		REG_START_X     = 3'd0,
		REG_START_Y     = 3'd1,
		REG_RECT_WIDTH  = 3'd2,
		REG_RECT_HEIGHT = 3'd3,
		REG_SRC_STRIDE  = 3'd4,
		REG_FILL_INDEX  = 3'd5,
		REG_FILL_MODE   = 3'd6
	} reg_idx_t;

	// Configuration register set.
	typedef struct packed {
		logic [9:0] start_x;
		logic [8:0] start_y;
		logic [9:0] rect_width;
		logic [8:0] rect_height;
		logic [9:0] src_stride;
		logic [7:0] fill_index;
		logic       fill_mode;
	} cfg_t;

	// Per-pixel information produced by the walker.
	typedef struct packed {
		logic [17:0] addr;
		logic        last;
		logic        off;
		logic        pal_oob;
	} pix_t;

endpackage

>>> sv/prb_in_if.sv
// ----------------------------------------------------------------------------
// prb_in_if: input channel of the blitter.
// Carries palette loads and blit steps with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface prb_in_if;

	logic                valid;
	logic                ready;
	prb_pkg::cmd_t       cmd;
	logic [7:0]          entry_index;
	logic [31:0]         entry_color;
	logic [7:0]          src_byte;

	modport source (
		output valid, cmd, entry_index, entry_color, src_byte,
		input  ready
	);

	modport sink (
		input  valid, cmd, entry_index, entry_color, src_byte,
		output ready
	);

endinterface

>>> sv/prb_out_if.sv
// ----------------------------------------------------------------------------
// prb_out_if: pixel output channel of the blitter.
// Carries one framebuffer write per transaction with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface prb_out_if;

	logic        valid;
	logic        ready;
	logic [17:0] pixel_address;
	logic [31:0] pixel_color;
	logic        last_pixel;
	logic        off_screen;

	modport source (
		output valid, pixel_address, pixel_color, last_pixel, off_screen,
		input  ready
	);

	modport sink (
		input  valid, pixel_address, pixel_color, last_pixel, off_screen,
		output ready
	);

endinterface

>>> sv/prb_ram.sv
// ----------------------------------------------------------------------------
// prb_ram: generic simple dual-port RAM.
// One write port and one read port with a registered read and read enable.
// ----------------------------------------------------------------------------
module prb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/prb_cfg.sv
// ----------------------------------------------------------------------------
// prb_cfg: configuration registers of the blitter.
// Captures writes from the plain write port into the register set.
// ----------------------------------------------------------------------------
module prb_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [prb_pkg::REG_IDX_W-1:0]    wr_index,
	input  logic [prb_pkg::REG_DATA_W-1:0]   wr_data,
	output prb_pkg::cfg_t                    cfg
);

	prb_pkg::cfg_t cfg_q;

	// Register writes; indexes beyond the set are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_x     <= 10'd0;
			cfg_q.start_y     <= 9'd0;
			cfg_q.rect_width  <= 10'd1;
			cfg_q.rect_height <= 9'd1;
			cfg_q.src_stride  <= 10'd1;
			cfg_q.fill_index  <= 8'd0;
			cfg_q.fill_mode   <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				prb_pkg::REG_START_X:     cfg_q.start_x     <= wr_data[9:0];
				prb_pkg::REG_START_Y:     cfg_q.start_y     <= wr_data[8:0];
				prb_pkg::REG_RECT_WIDTH:  cfg_q.rect_width  <= wr_data[9:0];
				prb_pkg::REG_RECT_HEIGHT: cfg_q.rect_height <= wr_data[8:0];
				prb_pkg::REG_SRC_STRIDE:  cfg_q.src_stride  <= wr_data[9:0];
				prb_pkg::REG_FILL_INDEX:  cfg_q.fill_index  <= wr_data[7:0];
				prb_pkg::REG_FILL_MODE:   cfg_q.fill_mode   <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> sv/prb_walker.sv
// ----------------------------------------------------------------------------
// prb_walker: rectangle walker of the blitter.
// Holds the column, row and padding counters, decides whether a step makes
// a pixel, and works out the pixel's address, flags and palette index.
// ----------------------------------------------------------------------------
module prb_walker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     src_byte,
	input  prb_pkg::cfg_t  cfg,
	output logic           emit,
	output prb_pkg::pix_t  pix,
	output logic [7:0]     rd_index
);

	logic [9:0]  col_q;
	logic [8:0]  row_q;
	logic [9:0]  pad_q;

	logic        pad_skip;
	logic [9:0]  w;
	logic [8:0]  h;
	logic [9:0]  stride;
	logic [10:0] col_inc;
	logic [9:0]  row_inc;
	logic        row_end;
	logic        last;
	logic [10:0] x;
	logic [9:0]  y;

	// Effective geometry: zero sizes count as one, a short stride as the width.
	always_comb begin
		w        = (cfg.rect_width == 10'd0) ? 10'd1 : cfg.rect_width;
		h        = (cfg.rect_height == 9'd0) ? 9'd1 : cfg.rect_height;
		stride   = (cfg.src_stride < w) ? w : cfg.src_stride;
		pad_skip = !cfg.fill_mode && (pad_q != 10'd0);
		col_inc  = {1'b0, col_q} + 11'd1;
		row_inc  = {1'b0, row_q} + 10'd1;
		row_end  = col_inc >= {1'b0, w};
		last     = row_end && (row_inc >= {1'b0, h});
	end

	// Screen position, framebuffer address and off-screen flag.
	always_comb begin
		x            = {1'b0, cfg.start_x} + {1'b0, col_q};
		y            = {1'b0, cfg.start_y} + {1'b0, row_q};
		pix.addr     = 18'({8'd0, y} * 18'(prb_pkg::SCREEN_WIDTH) + {7'd0, x});
		pix.last     = last;
		pix.off      = ({2'd0, x} >= prb_pkg::COORD_W'(prb_pkg::SCREEN_WIDTH)) ||
		               ({3'd0, y} >= prb_pkg::COORD_W'(prb_pkg::SCREEN_HEIGHT));
		rd_index     = cfg.fill_mode ? cfg.fill_index : src_byte;
		pix.pal_oob  = {1'b0, rd_index} >= 9'(prb_pkg::PAL_DEPTH);
		emit         = step && !pad_skip;
	end

	// Counter update on each step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= 10'd0;
			row_q <= 9'd0;
			pad_q <= 10'd0;
		end else if (step) begin
			if (pad_skip) begin
				pad_q <= pad_q - 10'd1;
			end else if (last) begin
				col_q <= 10'd0;
				row_q <= 9'd0;
				pad_q <= 10'd0;
			end else if (row_end) begin
				col_q <= 10'd0;
				row_q <= row_inc[8:0];
				pad_q <= cfg.fill_mode ? 10'd0 : (stride - w);
			end else begin
				col_q <= col_inc[9:0];
			end
		end
	end

endmodule

>>> sv/palette_rect_blitter.sv
// ----------------------------------------------------------------------------
// palette_rect_blitter: indexed-colour rectangle blitter.
// Input transactions either load one palette entry (cmd load) or advance the
// blit by one step (cmd step). In copy mode each step carries one source
// byte; bytes beyond the rectangle width of each source row are dropped. In
// fill mode every step paints the configured fill colour. Each pixel leaves
// on the output channel as one transaction with its framebuffer word
// address, its colour, a last flag and an off-screen flag.
// Configuration goes through the write port (wr_en, wr_index, wr_data) and
// is to be written by the user while the block is idle; the block does not enforce it.
// A pixel passes the palette read stage and the output register. Throughput:
// one transaction per cycle while the receiver is ready; the single read
// port of the palette RAM is used once per pixel and the write port once
// per load. A stalled receiver holds the output register; one more pixel
// waits in the palette read stage, after which the input ready drops until it moves on.
// Reset clears the counters, the pipeline and the registers to their
// defaults; the palette is undefined until loaded and needs no clearing.
// ----------------------------------------------------------------------------
module palette_rect_blitter (
	input  logic                           clk,
	input  logic                           arst_n,
	prb_in_if.sink                         item_in,
	prb_out_if.source                      pixel_out,
	input  logic                           wr_en,
	input  logic [prb_pkg::REG_IDX_W-1:0]  wr_index,
	input  logic [prb_pkg::REG_DATA_W-1:0] wr_data
);

	prb_pkg::cfg_t   cfg;
	prb_pkg::pix_t   pix;
	logic            emit;
	logic [7:0]      rd_index;
	logic            in_ready;
	logic            in_acc;
	logic            step;
	logic            pal_we;
	logic [31:0]     pal_rdata;
	logic            s2_free;

	logic            valid_s1;
	prb_pkg::pix_t   pix_s1;

	logic            valid_s2;
	logic [17:0]     addr_s2;
	logic [31:0]     color_s2;
	logic            last_s2;
	logic            off_s2;

	// Configuration registers.
	prb_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// Handshake: the read stage empties or moves on whenever the output is free.
	assign s2_free       = !valid_s2 || pixel_out.ready;
	assign in_ready      = !valid_s1 || s2_free;
	assign item_in.ready = in_ready;
	assign in_acc        = item_in.valid && in_ready;
	assign step          = in_acc && (item_in.cmd == prb_pkg::CMD_STEP);
	assign pal_we        = in_acc && (item_in.cmd == prb_pkg::CMD_LOAD) &&
	                       ({1'b0, item_in.entry_index} < 9'(prb_pkg::PAL_DEPTH));

	// Rectangle walker.
	prb_walker u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.src_byte (item_in.src_byte),
		.cfg      (cfg),
		.emit     (emit),
		.pix      (pix),
		.rd_index (rd_index)
	);

	// Palette memory: loads write, pixels read.
	prb_ram #(
		.WIDTH (32),
		.DEPTH (prb_pkg::PAL_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (pal_we),
		.waddr (item_in.entry_index[prb_pkg::PAL_AW-1:0]),
		.wdata (item_in.entry_color),
		.re    (emit),
		.raddr (rd_index[prb_pkg::PAL_AW-1:0]),
		.rdata (pal_rdata)
	);

	// Read stage: pixel information waits here for the palette data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pix_s1 <= pix;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			addr_s2  <= pix_s1.addr;
			color_s2 <= pix_s1.pal_oob ? 32'd0 : pal_rdata;
			last_s2  <= pix_s1.last;
			off_s2   <= pix_s1.off;
		end
	end

	assign pixel_out.valid         = valid_s2;
	assign pixel_out.pixel_address = addr_s2;
	assign pixel_out.pixel_color   = color_s2;
	assign pixel_out.last_pixel    = last_s2;
	assign pixel_out.off_screen    = off_s2;

endmodule

>>> sv/prb_checker.sv
// ----------------------------------------------------------------------------
// prb_checker: port-level checks of the blitter.
// Watches the channels of the top level and is attached to it by a bind.
// ----------------------------------------------------------------------------
module prb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [17:0] pixel_address,
	input logic [31:0] pixel_color,
	input logic        last_pixel,
	input logic        off_screen
);

	// A pending output transaction stays until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output transaction dropped while stalled");

	// A stalled output transaction keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pixel_address) && $stable(pixel_color) &&
			$stable(last_pixel) && $stable(off_screen))
		else $error("output payload changed while stalled");

	// With the output register empty the block always takes input.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

	// An on-screen pixel addresses a word inside the framebuffer.
	a_onscreen_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !off_screen |->
			{14'd0, pixel_address} < 32'(prb_pkg::SCREEN_WIDTH * prb_pkg::SCREEN_HEIGHT))
		else $error("on-screen pixel outside the framebuffer");

endmodule

bind palette_rect_blitter prb_checker u_prb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (item_in.ready),
	.out_valid     (pixel_out.valid),
	.out_ready     (pixel_out.ready),
	.pixel_address (pixel_out.pixel_address),
	.pixel_color   (pixel_out.pixel_color),
	.last_pixel    (pixel_out.last_pixel),
	.off_screen    (pixel_out.off_screen)
);
